// ===== design/slb_pkg.sv =====
// Shared constants, state codes and the result record for the sentence length
// burstiness block. No dependencies.
`default_nettype none

package slb_pkg;

  localparam int WORD_COUNT_BITS     = 12;
  localparam int SENTENCE_COUNT_BITS = 16;

  localparam int CV_BITS     = 24;
  localparam int CONS_BITS   = 17;
  localparam int TOTAL_BITS  = 16;

  // consistency = 2^32 / (65536 + cv): 33 dividend bits, 25-bit divisor
  localparam int DIVC_STEPS    = 33;
  localparam int DIVC_DEN_BITS = 25;
  localparam int DIVC_REM_BITS = 26;
  localparam logic [DIVC_DEN_BITS-1:0] DIVC_BASE = 25'd65536;

  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = 16'hFFFF;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MULQ = 7'b0000010,
    ST_MULS = 7'b0000100,
    ST_ROOT = 7'b0001000,
    ST_DIVS = 7'b0010000,
    ST_DIVC = 7'b0100000,
    ST_DONE = 7'b1000000
  } seq_state_t;

  typedef struct packed {
    logic [CV_BITS-1:0]    burstiness_q16;
    logic [CONS_BITS-1:0]  consistency_q16;
    logic [TOTAL_BITS-1:0] sentence_total;
    logic                  count_overflow;
  } slb_result_t;

endpackage

`default_nettype wire

// ===== design/slb_if.sv =====
// Valid/ready channel interfaces for the text byte items and the result items.
// Depends on nothing.
`default_nettype none

interface slb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       has_char;
  logic       end_of_sentence;
  logic       end_of_text;

  modport source (output valid, char_byte, has_char, end_of_sentence, end_of_text,
                  input ready);
  modport sink   (input valid, char_byte, has_char, end_of_sentence, end_of_text,
                  output ready);
endinterface

interface slb_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] burstiness_q16;
  logic [16:0] consistency_q16;
  logic [15:0] sentence_total;
  logic        count_overflow;

  modport source (output valid, burstiness_q16, consistency_q16, sentence_total,
                  count_overflow, input ready);
  modport sink   (input valid, burstiness_q16, consistency_q16, sentence_total,
                  count_overflow, output ready);
endinterface

`default_nettype wire

// ===== design/slb_accum.sv =====
// Word and sentence statistics: word count, running square, n, S and Q.
// Depends on slb_pkg.
`default_nettype none

module slb_accum #(
  parameter int WORD_COUNT_BITS     = slb_pkg::WORD_COUNT_BITS,
  parameter int SENTENCE_COUNT_BITS = slb_pkg::SENTENCE_COUNT_BITS
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      accept,
  input  wire logic [7:0]                                char_byte,
  input  wire logic                                      has_char,
  input  wire logic                                      end_of_sentence,
  input  wire logic                                      end_of_text,
  output logic [SENTENCE_COUNT_BITS-1:0]                 n_post,
  output logic [WORD_COUNT_BITS+SENTENCE_COUNT_BITS-1:0] s_post,
  output logic [2*WORD_COUNT_BITS+SENTENCE_COUNT_BITS-1:0] q_post,
  output logic                                           sat_post
);

  localparam int WB = WORD_COUNT_BITS;
  localparam int SB = SENTENCE_COUNT_BITS;
  localparam int SW = WB + SB;
  localparam int QW = 2 * WB + SB;

  logic          inside_r, inside_nxt, inside_a;
  logic [WB-1:0] words_r, words_nxt, words_a;
  logic [2*WB-1:0] wsq_r, wsq_nxt, wsq_a;
  logic [SB-1:0] n_r, n_nxt, n_a;
  logic [SW-1:0] s_r, s_nxt, s_a;
  logic [QW-1:0] q_r, q_nxt, q_a;
  logic          sat_r, sat_nxt, sat_a;
  logic          is_space;

  assign is_space = (char_byte == slb_pkg::CHAR_SPACE) ||
                    ((char_byte >= slb_pkg::CHAR_TAB) && (char_byte <= slb_pkg::CHAR_CR));

  always_comb begin
    inside_a = inside_r;
    words_a  = words_r;
    wsq_a    = wsq_r;
    n_a      = n_r;
    s_a      = s_r;
    q_a      = q_r;
    sat_a    = sat_r;
    if (has_char) begin
      if (is_space) begin
        inside_a = 1'b0;
      end else if (!inside_r) begin
        inside_a = 1'b1;
        if (words_r == '1) begin
          sat_a = 1'b1;
        end else begin
          words_a = words_r + 1'b1;
          // (w+1)^2 = w^2 + 2w + 1
          wsq_a   = wsq_r + (2*WB)'({words_r, 1'b1});
        end
      end
    end
    if (end_of_sentence) begin
      if (n_r == '1) begin
        sat_a = 1'b1;
      end else begin
        n_a = n_r + 1'b1;
        s_a = s_r + SW'(words_a);
        q_a = q_r + QW'(wsq_a);
      end
      words_a  = '0;
      wsq_a    = '0;
      inside_a = 1'b0;
    end
  end

  assign n_post   = n_a;
  assign s_post   = s_a;
  assign q_post   = q_a;
  assign sat_post = sat_a;

  always_comb begin
    inside_nxt = inside_r;
    words_nxt  = words_r;
    wsq_nxt    = wsq_r;
    n_nxt      = n_r;
    s_nxt      = s_r;
    q_nxt      = q_r;
    sat_nxt    = sat_r;
    if (accept) begin
      if (end_of_text) begin
        inside_nxt = 1'b0;
        words_nxt  = '0;
        wsq_nxt    = '0;
        n_nxt      = '0;
        s_nxt      = '0;
        q_nxt      = '0;
        sat_nxt    = 1'b0;
      end else begin
        inside_nxt = inside_a;
        words_nxt  = words_a;
        wsq_nxt    = wsq_a;
        n_nxt      = n_a;
        s_nxt      = s_a;
        q_nxt      = q_a;
        sat_nxt    = sat_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      words_r  <= '0;
      wsq_r    <= '0;
      n_r      <= '0;
      s_r      <= '0;
      q_r      <= '0;
      sat_r    <= 1'b0;
    end else begin
      inside_r <= inside_nxt;
      words_r  <= words_nxt;
      wsq_r    <= wsq_nxt;
      n_r      <= n_nxt;
      s_r      <= s_nxt;
      q_r      <= q_nxt;
      sat_r    <= sat_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/slb_addsub.sv =====
// Shared adder/subtractor; carry out is the no-borrow compare on subtract.
// Depends on nothing.
`default_nettype none

module slb_addsub #(
  parameter int W = 32
) (
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  input  wire logic         sub,
  output logic [W-1:0]      y,
  output logic              cout
);

  assign {cout, y} = {1'b0, a} + {1'b0, b ^ {W{sub}}} + {{W{1'b0}}, sub};

endmodule

`default_nettype wire

// ===== design/slb_cv_seq.sv =====
// Sequencer for the end-of-text math: nQ - S^2 by shift-add, bit-pair square
// root, restoring divisions by S and by 65536+cv, all on one slb_addsub.
// Depends on slb_pkg and slb_addsub.
`default_nettype none

module slb_cv_seq #(
  parameter int WORD_COUNT_BITS     = slb_pkg::WORD_COUNT_BITS,
  parameter int SENTENCE_COUNT_BITS = slb_pkg::SENTENCE_COUNT_BITS
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire logic                                        start,
  input  wire logic [SENTENCE_COUNT_BITS-1:0]              n_in,
  input  wire logic [WORD_COUNT_BITS+SENTENCE_COUNT_BITS-1:0] s_in,
  input  wire logic [2*WORD_COUNT_BITS+SENTENCE_COUNT_BITS-1:0] q_in,
  input  wire logic                                        sat_in,
  input  wire logic                                        grant,
  output logic                                             busy,
  output logic                                             done,
  output slb_pkg::slb_result_t                             result
);

  localparam int WB  = WORD_COUNT_BITS;
  localparam int SB  = SENTENCE_COUNT_BITS;
  localparam int SW  = WB + SB;
  localparam int PW  = 3 * WB + 2 * SB;
  localparam int RW  = (PW + 33) / 2;
  localparam int XW  = 2 * RW;
  localparam int RM0 = (RW + 2 > SW + 1) ? RW + 2 : SW + 1;
  localparam int RMW = (RM0 > slb_pkg::DIVC_REM_BITS) ? RM0 : slb_pkg::DIVC_REM_BITS;
  localparam int UW  = (PW > RMW) ? PW : RMW;
  localparam int MS0 = (RW > SW) ? RW : SW;
  localparam int MAXSTEP = (MS0 > slb_pkg::DIVC_STEPS) ? MS0 : slb_pkg::DIVC_STEPS;
  localparam int CW  = $clog2(MAXSTEP);
  localparam int NTW = (SB > slb_pkg::TOTAL_BITS) ? SB : slb_pkg::TOTAL_BITS;
  localparam int CVB = slb_pkg::CV_BITS;
  localparam int DRB = slb_pkg::DIVC_REM_BITS;

  slb_pkg::seq_state_t state_r, state_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [PW-1:0]  acc_r, acc_nxt;
  logic [PW-1:0]  mcand_r, mcand_nxt;
  logic [SW-1:0]  mplier_r, mplier_nxt;
  logic [XW-1:0]  xr_r, xr_nxt;
  logic [RMW-1:0] rem_r, rem_nxt;
  logic [RW-1:0]  root_r, root_nxt;
  logic [CVB-1:0] c_r, c_nxt;
  logic [slb_pkg::CONS_BITS-1:0] q_r, q_nxt;
  logic [SB-1:0]  n_r, n_nxt;
  logic [SW-1:0]  s_r, s_nxt;
  logic           sat_r, sat_nxt;

  logic [UW-1:0]  alu_a, alu_b, alu_y;
  logic           alu_sub, alu_co;
  logic [RW-1:0]  root_step;
  logic [CVB-1:0] c_sat;
  logic [NTW-1:0] n_wide;

  slb_addsub #(.W(UW)) u_addsub (
    .a    (alu_a),
    .b    (alu_b),
    .sub  (alu_sub),
    .y    (alu_y),
    .cout (alu_co)
  );

  // operand select for the shared unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    case (state_r)
      slb_pkg::ST_MULQ: begin
        alu_a   = UW'(acc_r);
        alu_b   = mplier_r[0] ? UW'(mcand_r) : '0;
        alu_sub = 1'b0;
      end
      slb_pkg::ST_MULS: begin
        alu_a   = UW'(acc_r);
        alu_b   = mplier_r[0] ? UW'(mcand_r) : '0;
        alu_sub = 1'b1;
      end
      slb_pkg::ST_ROOT: begin
        alu_a = UW'({rem_r[RW-1:0], xr_r[XW-1 -: 2]});
        alu_b = UW'({root_r, 2'b01});
      end
      slb_pkg::ST_DIVS: begin
        alu_a = UW'({rem_r[SW-1:0], root_r[RW-1]});
        alu_b = UW'(s_r);
      end
      slb_pkg::ST_DIVC: begin
        // dividend 2^32: a single one bit on the first step
        alu_a = UW'({rem_r[DRB-2:0], (cnt_r == '0)});
        alu_b = UW'(slb_pkg::DIVC_BASE + slb_pkg::DIVC_DEN_BITS'(c_r));
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
      end
    endcase
  end

  assign root_step = {root_r[RW-2:0], alu_co};
  assign c_sat     = (|root_step[RW-1:CVB]) ? '1 : root_step[CVB-1:0];

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    xr_nxt     = xr_r;
    rem_nxt    = rem_r;
    root_nxt   = root_r;
    c_nxt      = c_r;
    q_nxt      = q_r;
    n_nxt      = n_r;
    s_nxt      = s_r;
    sat_nxt    = sat_r;
    case (state_r)
      slb_pkg::ST_IDLE: begin
        if (start) begin
          n_nxt      = n_in;
          s_nxt      = s_in;
          sat_nxt    = sat_in;
          acc_nxt    = '0;
          mcand_nxt  = PW'(q_in);
          mplier_nxt = SW'(n_in);
          cnt_nxt    = '0;
          rem_nxt    = '0;
          c_nxt      = '0;
          // fewer than two sentences or no words: cv is zero
          if ((n_in < SB'(2)) || (s_in == '0)) begin
            state_nxt = slb_pkg::ST_DIVC;
          end else begin
            state_nxt = slb_pkg::ST_MULQ;
          end
        end
      end
      slb_pkg::ST_MULQ: begin
        acc_nxt    = alu_y[PW-1:0];
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CW'(SB - 1)) begin
          mcand_nxt  = PW'(s_r);
          mplier_nxt = s_r;
          cnt_nxt    = '0;
          state_nxt  = slb_pkg::ST_MULS;
        end
      end
      slb_pkg::ST_MULS: begin
        acc_nxt    = alu_y[PW-1:0];
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CW'(SW - 1)) begin
          xr_nxt    = XW'({alu_y[PW-1:0], 32'b0});
          rem_nxt   = '0;
          root_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = slb_pkg::ST_ROOT;
        end
      end
      slb_pkg::ST_ROOT: begin
        rem_nxt  = alu_co ? RMW'(alu_y[RW+1:0]) : RMW'(alu_a[RW+1:0]);
        root_nxt = root_step;
        xr_nxt   = xr_r << 2;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CW'(RW - 1)) begin
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = slb_pkg::ST_DIVS;
        end
      end
      slb_pkg::ST_DIVS: begin
        // quotient bits replace root bits as they shift out
        rem_nxt  = alu_co ? RMW'(alu_y[SW:0]) : RMW'(alu_a[SW:0]);
        root_nxt = root_step;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CW'(RW - 1)) begin
          c_nxt     = c_sat;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = slb_pkg::ST_DIVC;
        end
      end
      slb_pkg::ST_DIVC: begin
        rem_nxt = alu_co ? RMW'(alu_y[DRB-1:0]) : RMW'(alu_a[DRB-1:0]);
        q_nxt   = {q_r[slb_pkg::CONS_BITS-2:0], alu_co};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(slb_pkg::DIVC_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = slb_pkg::ST_DONE;
        end
      end
      slb_pkg::ST_DONE: begin
        if (grant) begin
          state_nxt = slb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = slb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slb_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    xr_r     <= xr_nxt;
    rem_r    <= rem_nxt;
    root_r   <= root_nxt;
    c_r      <= c_nxt;
    q_r      <= q_nxt;
    n_r      <= n_nxt;
    s_r      <= s_nxt;
    sat_r    <= sat_nxt;
  end

  assign n_wide = NTW'(n_r);

  assign busy = (state_r != slb_pkg::ST_IDLE);
  assign done = (state_r == slb_pkg::ST_DONE);

  assign result.burstiness_q16  = c_r;
  assign result.consistency_q16 = q_r;
  assign result.sentence_total  = (n_wide > NTW'(slb_pkg::TOTAL_MAX)) ?
                                  slb_pkg::TOTAL_MAX : n_wide[slb_pkg::TOTAL_BITS-1:0];
  assign result.count_overflow  = sat_r;

endmodule

`default_nettype wire

// ===== design/sentence_length_burstiness_top.sv =====
// Text items without end_of_text are taken one per cycle while slb_cv_seq is idle.
// An end_of_text item keeps in ready low while slb_cv_seq works the math on its
// shared adder (only the division by 65536+cv when fewer than two sentences or no
// words) and until the result is loaded into the output register.
// The result then waits in an output register until taken.
// Synchronous active-low reset clears all counts and the sequencer.
`default_nettype none

module sentence_length_burstiness_top #(
  parameter int WORD_COUNT_BITS     = slb_pkg::WORD_COUNT_BITS,
  parameter int SENTENCE_COUNT_BITS = slb_pkg::SENTENCE_COUNT_BITS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  slb_in_if.sink    in_ch,
  slb_out_if.source out_ch
);

  localparam int SW = WORD_COUNT_BITS + SENTENCE_COUNT_BITS;
  localparam int QW = 2 * WORD_COUNT_BITS + SENTENCE_COUNT_BITS;

  logic                           accept;
  logic [SENTENCE_COUNT_BITS-1:0] n_post;
  logic [SW-1:0]                  s_post;
  logic [QW-1:0]                  q_post;
  logic                           sat_post;
  logic                           busy;
  logic                           done;
  logic                           load;
  slb_pkg::slb_result_t           result;
  slb_pkg::slb_result_t           out_r;
  logic                           out_valid_r, out_valid_nxt;

  assign in_ch.ready = ~busy;
  assign accept      = in_ch.valid & ~busy;

  slb_accum #(
    .WORD_COUNT_BITS     (WORD_COUNT_BITS),
    .SENTENCE_COUNT_BITS (SENTENCE_COUNT_BITS)
  ) u_accum (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .char_byte       (in_ch.char_byte),
    .has_char        (in_ch.has_char),
    .end_of_sentence (in_ch.end_of_sentence),
    .end_of_text     (in_ch.end_of_text),
    .n_post          (n_post),
    .s_post          (s_post),
    .q_post          (q_post),
    .sat_post        (sat_post)
  );

  slb_cv_seq #(
    .WORD_COUNT_BITS     (WORD_COUNT_BITS),
    .SENTENCE_COUNT_BITS (SENTENCE_COUNT_BITS)
  ) u_cv_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept & in_ch.end_of_text),
    .n_in   (n_post),
    .s_in   (s_post),
    .q_in   (q_post),
    .sat_in (sat_post),
    .grant  (load),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  // output register takes the result when empty or being drained
  assign load = done & (~out_valid_r | out_ch.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= result;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.burstiness_q16  = out_r.burstiness_q16;
  assign out_ch.consistency_q16 = out_r.consistency_q16;
  assign out_ch.sentence_total  = out_r.sentence_total;
  assign out_ch.count_overflow  = out_r.count_overflow;

endmodule

`default_nettype wire
